// ===== sv/frustum_cull_box_sphere_assert.svh =====
// Assertion macros for the frustum culling block.
// Included by frustum_cull_box_sphere.sv; the macros expect clk and arst_n in scope.
`ifndef FRUSTUM_CULL_BOX_SPHERE_ASSERT_SVH
`define FRUSTUM_CULL_BOX_SPHERE_ASSERT_SVH

`define FCBS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define FCBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/fcbs_pkg.sv =====
// Package for the frustum culling block: action codes, plane entry type, defaults and the sat16 clamp.
// No dependencies.
`timescale 1ns / 1ps

package fcbs_pkg;

	localparam int NUM_PLANES_DEF = 6;
	localparam int COORD_BITS_DEF = 24;
	localparam int MAX_TEST_PLANES = 6;
	localparam int FIELD_W = 24;
	localparam int NORM_W = 16;
	localparam int DIST_W = 32;
	localparam int RAD_W = 23;
	localparam int SLOT_W = 3;
	localparam int MASK_W = 6;
	localparam int DIST_SHIFT = 14;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_BOX    = 2'd1,
		ACT_SPHERE = 2'd2
	} action_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
		logic signed [DIST_W-1:0] offset;
	} plane_t;

	function automatic logic signed [NORM_W-1:0] sat16(input logic signed [FIELD_W-1:0] v);
		logic signed [NORM_W-1:0] r;
		if (v > 24'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -24'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[NORM_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/frustum_cull_box_sphere.sv =====
// Frustum culling of boxes and spheres against a loaded plane table.
// One word is accepted every cycle unless back-pressure from out_ready fills the stages.
// Each stage holds a word while the stage after it is full, so stalls lose nothing.
// The multipliers of stage two set the clock; all planes are tested side by side.
// arst_n clears the valid bits and culling_disabled; the plane table is not reset.
// Depends on fcbs_pkg and frustum_cull_box_sphere_assert.svh.
`timescale 1ns / 1ps

module frustum_cull_box_sphere #(
	parameter int NUM_PLANES = fcbs_pkg::NUM_PLANES_DEF,
	parameter int COORD_BITS = fcbs_pkg::COORD_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr_en,
	input  logic                                    cfg_wr_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [1:0]                              action,
	input  logic [fcbs_pkg::SLOT_W-1:0]             plane_slot,
	input  logic [fcbs_pkg::MASK_W-1:0]             plane_mask,
	input  logic signed [fcbs_pkg::FIELD_W-1:0]     first_x,
	input  logic signed [fcbs_pkg::FIELD_W-1:0]     first_y,
	input  logic signed [fcbs_pkg::FIELD_W-1:0]     first_z,
	input  logic signed [fcbs_pkg::FIELD_W-1:0]     second_x,
	input  logic signed [fcbs_pkg::FIELD_W-1:0]     second_y,
	input  logic signed [fcbs_pkg::FIELD_W-1:0]     second_z,
	input  logic signed [fcbs_pkg::DIST_W-1:0]      plane_distance,
	input  logic [fcbs_pkg::RAD_W-1:0]              sphere_radius,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic                                    culled
);

	localparam int NT = (NUM_PLANES < fcbs_pkg::MAX_TEST_PLANES) ?
		NUM_PLANES : fcbs_pkg::MAX_TEST_PLANES;
	localparam int CW = COORD_BITS;
	localparam int PW = CW + fcbs_pkg::NORM_W;
	localparam int DW = PW + 2;
	localparam int TW = fcbs_pkg::DIST_W + 1 + fcbs_pkg::DIST_SHIFT;
	localparam int CMPW = (DW > TW) ? DW : TW;

	function automatic logic signed [CW-1:0] to_coord(input logic [fcbs_pkg::FIELD_W-1:0] raw);
		return $signed(CW'(raw));
	endfunction

	logic                                culling_disabled_q;
	fcbs_pkg::plane_t                    plane_q [NUM_PLANES];

	logic                                rdy2, rdy3, rdy4;

	logic                                valid_s1;
	fcbs_pkg::action_t                   action_s1;
	logic [fcbs_pkg::SLOT_W-1:0]         slot_s1;
	logic [NT-1:0]                       mask_s1;
	logic [fcbs_pkg::FIELD_W-1:0]        first_s1 [3];
	logic [fcbs_pkg::FIELD_W-1:0]        second_s1 [3];
	logic signed [fcbs_pkg::DIST_W-1:0]  dist_s1;
	logic [fcbs_pkg::RAD_W-1:0]          radius_s1;

	logic                                valid_s2;
	fcbs_pkg::action_t                   action_s2;
	logic [NT-1:0]                       mask_s2;
	logic signed [PW-1:0]                prod_s2 [NT][3];
	logic signed [fcbs_pkg::DIST_W-1:0]  off_s2 [NT];
	logic [fcbs_pkg::RAD_W-1:0]          radius_s2;

	logic                                valid_s3;
	fcbs_pkg::action_t                   action_s3;
	logic [NT-1:0]                       mask_s3;
	logic signed [CMPW-1:0]              dot_s3 [NT];
	logic signed [CMPW-1:0]              thr_s3 [NT];

	logic                                valid_s4;
	logic                                culled_s4;

	fcbs_pkg::plane_t                    new_plane;
	logic signed [PW-1:0]                prod_d [NT][3];
	logic signed [CMPW-1:0]              dot_d [NT];
	logic signed [CMPW-1:0]              thr_d [NT];
	logic                                culled_d;

	assign rdy4     = !valid_s4 || out_ready;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign in_ready = !valid_s1 || rdy2;
	assign out_valid = valid_s4;
	assign culled    = culled_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			culling_disabled_q <= 1'b0;
		end else if (cfg_wr_en) begin
			culling_disabled_q <= cfg_wr_data;
		end
	end

	// Stage 1: input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1    <= fcbs_pkg::action_t'(action);
			slot_s1      <= plane_slot;
			mask_s1      <= plane_mask[NT-1:0];
			first_s1[0]  <= $unsigned(first_x);
			first_s1[1]  <= $unsigned(first_y);
			first_s1[2]  <= $unsigned(first_z);
			second_s1[0] <= $unsigned(second_x);
			second_s1[1] <= $unsigned(second_y);
			second_s1[2] <= $unsigned(second_z);
			dist_s1      <= plane_distance;
			radius_s1    <= sphere_radius;
		end
	end

	// A load writes the table as it leaves stage 1, so later tests see it and earlier ones do not.
	always_comb begin
		new_plane.nx     = fcbs_pkg::sat16($signed(first_s1[0]));
		new_plane.ny     = fcbs_pkg::sat16($signed(first_s1[1]));
		new_plane.nz     = fcbs_pkg::sat16($signed(first_s1[2]));
		new_plane.offset = dist_s1;
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			if (valid_s1 && rdy2 && action_s1 == fcbs_pkg::ACT_LOAD &&
			    slot_s1 == fcbs_pkg::SLOT_W'(p)) begin
				plane_q[p] <= new_plane;
			end
		end
	end

	// Stage 2: pick the corner per axis and form the products.
	always_comb begin
		logic signed [fcbs_pkg::NORM_W-1:0] n [3];
		logic signed [CW-1:0]               c;
		for (int p = 0; p < NT; p++) begin
			n[0] = plane_q[p].nx;
			n[1] = plane_q[p].ny;
			n[2] = plane_q[p].nz;
			for (int a = 0; a < 3; a++) begin
				if (action_s1 == fcbs_pkg::ACT_BOX && !n[a][fcbs_pkg::NORM_W-1]) begin
					c = to_coord(second_s1[a]);
				end else begin
					c = to_coord(first_s1[a]);
				end
				prod_d[p][a] = PW'(n[a]) * PW'(c);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			action_s2 <= action_s1;
			mask_s2   <= mask_s1;
			radius_s2 <= radius_s1;
			for (int p = 0; p < NT; p++) begin
				off_s2[p] <= plane_q[p].offset;
				for (int a = 0; a < 3; a++) begin
					prod_s2[p][a] <= prod_d[p][a];
				end
			end
		end
	end

	// Stage 3: dot product and threshold per plane, both scaled to Q.22.
	always_comb begin
		logic signed [fcbs_pkg::DIST_W:0] diff;
		for (int p = 0; p < NT; p++) begin
			dot_d[p] = CMPW'(prod_s2[p][0]) + CMPW'(prod_s2[p][1]) + CMPW'(prod_s2[p][2]);
			if (action_s2 == fcbs_pkg::ACT_SPHERE) begin
				diff = (fcbs_pkg::DIST_W + 1)'(off_s2[p]) -
					$signed((fcbs_pkg::DIST_W + 1)'(radius_s2));
			end else begin
				diff = (fcbs_pkg::DIST_W + 1)'(off_s2[p]);
			end
			thr_d[p] = CMPW'(diff) <<< fcbs_pkg::DIST_SHIFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			action_s3 <= action_s2;
			mask_s3   <= mask_s2;
			for (int p = 0; p < NT; p++) begin
				dot_s3[p] <= dot_d[p];
				thr_s3[p] <= thr_d[p];
			end
		end
	end

	// Stage 4: compare per plane and merge into the output register.
	always_comb begin
		logic hit;
		logic is_test;
		hit = 1'b0;
		case (action_s3)
			fcbs_pkg::ACT_BOX: begin
				is_test = 1'b1;
				for (int p = 0; p < NT; p++) begin
					if (mask_s3[p] && dot_s3[p] < thr_s3[p]) begin
						hit = 1'b1;
					end
				end
			end
			fcbs_pkg::ACT_SPHERE: begin
				is_test = 1'b1;
				for (int p = 0; p < NT; p++) begin
					if (mask_s3[p] && dot_s3[p] <= thr_s3[p]) begin
						hit = 1'b1;
					end
				end
			end
			default: begin
				is_test = 1'b0;
			end
		endcase
		culled_d = is_test && hit && !culling_disabled_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (rdy4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && valid_s3) begin
			culled_s4 <= culled_d;
		end
	end

`include "frustum_cull_box_sphere_assert.svh"

	`FCBS_ASSERT_NEXT(a_load_not_culled, valid_s3 && rdy4 && action_s3 != fcbs_pkg::ACT_BOX && action_s3 != fcbs_pkg::ACT_SPHERE, valid_s4 && !culled_s4, "non-test word reported culled")
	`FCBS_ASSERT_NEXT(a_disabled_not_culled, valid_s3 && rdy4 && culling_disabled_q && !cfg_wr_en, valid_s4 && !culled_s4, "word culled while culling is disabled")
	`FCBS_ASSERT_NEXT(a_s1_holds, valid_s1 && !rdy2, valid_s1 && $stable(action_s1) && $stable(mask_s1), "stage 1 word changed while stalled")
	`FCBS_ASSERT_SAME(a_ready_when_empty, !valid_s1 || !valid_s2 || !valid_s3 || !valid_s4, in_ready, "input stalled with an empty stage in the pipeline")

endmodule

// ===== tb/sv/tb_frustum_cull_box_sphere.sv =====
// Self-checking testbench for frustum_cull_box_sphere: plane loads, box and sphere tests.
// Keeps its own plane table and predicts every culled bit; depends on fcbs_pkg and the RTL.
// Runs directed corner cases, then random streams with bursty input and a stalling output.
`timescale 1ns / 1ps

module tb_frustum_cull_box_sphere;

	localparam int NUM_PL = fcbs_pkg::NUM_PLANES_DEF;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int RESET_CYCLES = 12;
	localparam int HOLD_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 16;
	localparam int REPORT_LIMIT = 10;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_WORDS = 100;
	localparam int PRESSURE_WORDS = 60;
	localparam int RX_ALWAYS = 0;
	localparam int RX_COIN = 1;
	localparam int RX_ONE_IN_FOUR = 2;
	localparam int RX_RARE_STALL = 3;
	localparam logic signed [fcbs_pkg::FIELD_W-1:0] COORD_MIN = 24'sh800000;
	localparam logic signed [fcbs_pkg::FIELD_W-1:0] COORD_MAX = 24'sh7fffff;
	localparam logic [fcbs_pkg::RAD_W-1:0] RADIUS_MAX = 23'h7fffff;

	typedef struct {
		logic [1:0]                          act;
		logic [fcbs_pkg::SLOT_W-1:0]         slot;
		logic [fcbs_pkg::MASK_W-1:0]         mask;
		logic signed [fcbs_pkg::FIELD_W-1:0] lo_x;
		logic signed [fcbs_pkg::FIELD_W-1:0] lo_y;
		logic signed [fcbs_pkg::FIELD_W-1:0] lo_z;
		logic signed [fcbs_pkg::FIELD_W-1:0] hi_x;
		logic signed [fcbs_pkg::FIELD_W-1:0] hi_y;
		logic signed [fcbs_pkg::FIELD_W-1:0] hi_z;
		logic signed [fcbs_pkg::DIST_W-1:0]  offset_q8;
		logic [fcbs_pkg::RAD_W-1:0]          radius;
	} cull_word_t;

	typedef struct {
		int   seq;
		logic cull;
	} cull_expect_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] action;
	logic [fcbs_pkg::SLOT_W-1:0] plane_slot;
	logic [fcbs_pkg::MASK_W-1:0] plane_mask;
	logic signed [fcbs_pkg::FIELD_W-1:0] first_x;
	logic signed [fcbs_pkg::FIELD_W-1:0] first_y;
	logic signed [fcbs_pkg::FIELD_W-1:0] first_z;
	logic signed [fcbs_pkg::FIELD_W-1:0] second_x;
	logic signed [fcbs_pkg::FIELD_W-1:0] second_y;
	logic signed [fcbs_pkg::FIELD_W-1:0] second_z;
	logic signed [fcbs_pkg::DIST_W-1:0] plane_distance;
	logic [fcbs_pkg::RAD_W-1:0] sphere_radius;
	logic out_valid;
	logic out_ready;
	logic culled;

	fcbs_pkg::plane_t model_planes [NUM_PL];
	logic model_disabled = 1'b0;
	cull_expect_t pending_culls [$];

	int errors = 0;
	int words_sent = 0;
	int results_seen = 0;
	int culled_seen = 0;
	int loads_sent = 0;
	int boxes_sent = 0;
	int spheres_sent = 0;
	int unused_sent = 0;
	int cfg_writes = 0;
	int input_stalls = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int hold_tickets = 0;
	int hold_served = 0;

	frustum_cull_box_sphere u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.plane_slot     (plane_slot),
		.plane_mask     (plane_mask),
		.first_x        (first_x),
		.first_y        (first_y),
		.first_z        (first_z),
		.second_x       (second_x),
		.second_y       (second_y),
		.second_z       (second_z),
		.plane_distance (plane_distance),
		.sphere_radius  (sphere_radius),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.culled         (culled)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void flag_error(input string msg);
		errors++;
		if (errors <= REPORT_LIMIT) begin
			$display("ERROR: %s", msg);
		end
	endfunction

	function automatic logic signed [fcbs_pkg::NORM_W-1:0] clamp_normal(
		input logic signed [fcbs_pkg::FIELD_W-1:0] v);
		if (v > 32767) begin
			return 16'sh7fff;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return v[fcbs_pkg::NORM_W-1:0];
	endfunction

	// Applies one word to the local plane table and returns the culled bit it must produce.
	function automatic logic predict_cull(input cull_word_t w);
		longint lo [3];
		longint hi [3];
		longint nrm [3];
		longint dot;
		longint limit;
		logic hit;
		hit = 1'b0;
		lo[0] = w.lo_x;
		lo[1] = w.lo_y;
		lo[2] = w.lo_z;
		hi[0] = w.hi_x;
		hi[1] = w.hi_y;
		hi[2] = w.hi_z;
		if (w.act == fcbs_pkg::ACT_LOAD) begin
			if (w.slot < NUM_PL) begin
				model_planes[w.slot].nx = clamp_normal(w.lo_x);
				model_planes[w.slot].ny = clamp_normal(w.lo_y);
				model_planes[w.slot].nz = clamp_normal(w.lo_z);
				model_planes[w.slot].offset = w.offset_q8;
			end
		end else if ((w.act == fcbs_pkg::ACT_BOX || w.act == fcbs_pkg::ACT_SPHERE) &&
		             !model_disabled) begin
			for (int p = 0; p < NUM_PL; p++) begin
				if (w.mask[p] && !hit) begin
					nrm[0] = model_planes[p].nx;
					nrm[1] = model_planes[p].ny;
					nrm[2] = model_planes[p].nz;
					limit = longint'(model_planes[p].offset) <<< fcbs_pkg::DIST_SHIFT;
					dot = 0;
					for (int a = 0; a < 3; a++) begin
						if (w.act == fcbs_pkg::ACT_BOX) begin
							dot += nrm[a] * ((nrm[a] < 0) ? lo[a] : hi[a]);
						end else begin
							dot += nrm[a] * lo[a];
						end
					end
					if (w.act == fcbs_pkg::ACT_BOX) begin
						hit = (dot < limit);
					end else begin
						hit = (dot - limit <=
							-(longint'(w.radius) <<< fcbs_pkg::DIST_SHIFT));
					end
				end
			end
		end
		return hit;
	endfunction

	function automatic logic signed [fcbs_pkg::FIELD_W-1:0] rand_coord();
		if ($urandom_range(0, 7) == 0) begin
			return fcbs_pkg::FIELD_W'($urandom());
		end
		return fcbs_pkg::FIELD_W'(int'($urandom_range(0, 131071)) - 65536);
	endfunction

	function automatic logic signed [fcbs_pkg::FIELD_W-1:0] rand_normal();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			return fcbs_pkg::FIELD_W'($urandom());
		end
		if (roll == 1) begin
			return '0;
		end
		return fcbs_pkg::FIELD_W'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic cull_word_t random_word();
		cull_word_t w;
		int roll;
		bit ordered;
		roll = $urandom_range(0, 99);
		if (roll < 15) begin
			w.act = fcbs_pkg::ACT_LOAD;
		end else if (roll < 55) begin
			w.act = fcbs_pkg::ACT_BOX;
		end else if (roll < 95) begin
			w.act = fcbs_pkg::ACT_SPHERE;
		end else begin
			w.act = ACT_UNUSED;
		end
		w.slot = fcbs_pkg::SLOT_W'($urandom_range(0, 7));
		w.mask = fcbs_pkg::MASK_W'($urandom_range(0, 63));
		if (w.act == fcbs_pkg::ACT_LOAD) begin
			w.lo_x = rand_normal();
			w.lo_y = rand_normal();
			w.lo_z = rand_normal();
		end else begin
			w.lo_x = rand_coord();
			w.lo_y = rand_coord();
			w.lo_z = rand_coord();
		end
		ordered = ($urandom_range(0, 9) < 8);
		w.hi_x = ordered ? w.lo_x + fcbs_pkg::FIELD_W'($urandom_range(0, 32767)) : rand_coord();
		w.hi_y = ordered ? w.lo_y + fcbs_pkg::FIELD_W'($urandom_range(0, 32767)) : rand_coord();
		w.hi_z = ordered ? w.lo_z + fcbs_pkg::FIELD_W'($urandom_range(0, 32767)) : rand_coord();
		if ($urandom_range(0, 9) == 0) begin
			w.offset_q8 = $urandom();
		end else begin
			w.offset_q8 = fcbs_pkg::DIST_W'(int'($urandom_range(0, 262143)) - 131072);
		end
		if ($urandom_range(0, 9) == 0) begin
			w.radius = fcbs_pkg::RAD_W'($urandom());
		end else begin
			w.radius = fcbs_pkg::RAD_W'($urandom_range(0, 32767));
		end
		return w;
	endfunction

	task automatic send_word(input cull_word_t w);
		int gap;
		cull_expect_t e;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		in_valid <= 1'b1;
		action <= w.act;
		plane_slot <= w.slot;
		plane_mask <= w.mask;
		first_x <= w.lo_x;
		first_y <= w.lo_y;
		first_z <= w.lo_z;
		second_x <= w.hi_x;
		second_y <= w.hi_y;
		second_z <= w.hi_z;
		plane_distance <= w.offset_q8;
		sphere_radius <= w.radius;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		e.seq = words_sent;
		e.cull = predict_cull(w);
		pending_culls.push_back(e);
		words_sent++;
		if (w.act == fcbs_pkg::ACT_LOAD) begin
			loads_sent++;
		end else if (w.act == fcbs_pkg::ACT_BOX) begin
			boxes_sent++;
		end else if (w.act == fcbs_pkg::ACT_SPHERE) begin
			spheres_sent++;
		end else begin
			unused_sent++;
		end
	endtask

	task automatic send_load(input logic [fcbs_pkg::SLOT_W-1:0] slot,
		input logic signed [fcbs_pkg::FIELD_W-1:0] nx,
		input logic signed [fcbs_pkg::FIELD_W-1:0] ny,
		input logic signed [fcbs_pkg::FIELD_W-1:0] nz,
		input logic signed [fcbs_pkg::DIST_W-1:0] offset_q8);
		cull_word_t w;
		w = random_word();
		w.act = fcbs_pkg::ACT_LOAD;
		w.slot = slot;
		w.lo_x = nx;
		w.lo_y = ny;
		w.lo_z = nz;
		w.offset_q8 = offset_q8;
		send_word(w);
	endtask

	task automatic send_box(input logic [fcbs_pkg::MASK_W-1:0] mask,
		input logic signed [fcbs_pkg::FIELD_W-1:0] lx,
		input logic signed [fcbs_pkg::FIELD_W-1:0] ly,
		input logic signed [fcbs_pkg::FIELD_W-1:0] lz,
		input logic signed [fcbs_pkg::FIELD_W-1:0] hx,
		input logic signed [fcbs_pkg::FIELD_W-1:0] hy,
		input logic signed [fcbs_pkg::FIELD_W-1:0] hz);
		cull_word_t w;
		w = random_word();
		w.act = fcbs_pkg::ACT_BOX;
		w.mask = mask;
		w.lo_x = lx;
		w.lo_y = ly;
		w.lo_z = lz;
		w.hi_x = hx;
		w.hi_y = hy;
		w.hi_z = hz;
		send_word(w);
	endtask

	task automatic send_sphere(input logic [fcbs_pkg::MASK_W-1:0] mask,
		input logic signed [fcbs_pkg::FIELD_W-1:0] cx,
		input logic signed [fcbs_pkg::FIELD_W-1:0] cy,
		input logic signed [fcbs_pkg::FIELD_W-1:0] cz,
		input logic [fcbs_pkg::RAD_W-1:0] radius);
		cull_word_t w;
		w = random_word();
		w.act = fcbs_pkg::ACT_SPHERE;
		w.mask = mask;
		w.lo_x = cx;
		w.lo_y = cy;
		w.lo_z = cz;
		w.radius = radius;
		send_word(w);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_culls.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_culling(input logic value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_disabled = value;
		cfg_writes++;
	endtask

	task automatic test_reset_config();
		write_culling(1'b0);
	endtask

	task automatic test_plane_loads();
		send_load(0, 16384, 0, 0, 256);
		send_load(1, -16384, 0, 0, -2560);
		send_load(2, 0, 16384, 0, -2560);
		send_load(3, 0, 0, -16384, -2560);
		send_load(4, COORD_MAX, COORD_MIN, 100000, 32'sh7fffffff);
		send_load(5, -40000, 0, 32767, 32'sh80000000);
		send_load(6, rand_normal(), rand_normal(), rand_normal(), $urandom());
		send_load(7, COORD_MIN, COORD_MAX, 0, 32'sh80000000);
	endtask

	task automatic test_box_bounds();
		send_box(6'h00, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
		send_box(6'h3f, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
		send_box(6'h01, 0, 0, 0, 256, 0, 0);
		send_box(6'h01, 0, 0, 0, 255, 0, 0);
		send_box(6'h02, 5000, 0, 0, -5000, 0, 0);
		send_box(6'h30, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
	endtask

	task automatic test_sphere_bounds();
		send_sphere(6'h01, 156, 0, 0, 100);
		send_sphere(6'h01, 157, 0, 0, 100);
		send_sphere(6'h01, 256, 0, 0, 0);
		send_sphere(6'h3f, COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX);
		send_sphere(6'h0c, COORD_MAX, COORD_MAX, COORD_MAX, 0);
	endtask

	task automatic test_unused_action();
		cull_word_t w;
		w = random_word();
		w.act = ACT_UNUSED;
		w.mask = 6'h3f;
		w.lo_x = COORD_MIN;
		w.hi_x = COORD_MAX;
		send_word(w);
		w = random_word();
		w.act = ACT_UNUSED;
		send_word(w);
	endtask

	task automatic test_culling_disabled();
		write_culling(1'b1);
		send_box(6'h01, 0, 0, 0, 255, 0, 0);
		send_sphere(6'h01, 156, 0, 0, 100);
		send_load(0, 16384, 0, 0, 512);
		write_culling(1'b1);
		write_culling(1'b0);
		send_box(6'h01, 0, 0, 0, 511, 0, 0);
		send_sphere(6'h01, 412, 0, 0, 100);
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 1) begin
				write_culling(1'b1);
			end else if (phase == RANDOM_PHASES - 1) begin
				write_culling(1'($urandom_range(0, 1)));
			end else begin
				write_culling(1'b0);
			end
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 25 == 0) begin
					gaps_on = ($urandom_range(0, 3) != 0);
				end
				send_word(random_word());
			end
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_tickets++;
		repeat (PRESSURE_WORDS) send_word(random_word());
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid = 1'b0;
		action = fcbs_pkg::ACT_LOAD;
		plane_slot = '0;
		plane_mask = '0;
		first_x = '0;
		first_y = '0;
		first_z = '0;
		second_x = '0;
		second_y = '0;
		second_z = '0;
		plane_distance = '0;
		sphere_radius = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_plane_loads();
		test_box_bounds();
		test_sphere_bounds();
		test_unused_action();
		test_culling_disabled();
		test_random_traffic();
		test_backpressure();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_culls.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", pending_culls.size()));
		end
		$display("Sent %0d loads, %0d box tests, %0d sphere tests, %0d unused-action words;",
			loads_sent, boxes_sent, spheres_sent, unused_sent);
		$display("%0d of %0d results culled, %0d register writes, %0d input stall cycles.",
			culled_seen, results_seen, cfg_writes, input_stalls);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches in total", errors);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Output side: ready pattern changes mode at random intervals; a ticket asks for a long hold.
	initial begin
		int mode;
		int left;
		int phase;
		mode = RX_ALWAYS;
		left = 0;
		phase = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_tickets) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served++;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(RX_ALWAYS, RX_RARE_STALL);
					left = $urandom_range(16, 120);
				end
				left--;
				phase++;
				case (mode)
					RX_ALWAYS: begin
						out_ready <= 1'b1;
					end
					RX_COIN: begin
						out_ready <= 1'($urandom_range(0, 1));
					end
					RX_ONE_IN_FOUR: begin
						out_ready <= (phase % 4 == 0);
					end
					default: begin
						out_ready <= ($urandom_range(0, 7) != 0);
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cull_expect_t e;
		if (arst_n && in_valid && !in_ready) begin
			input_stalls++;
		end
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (culled === 1'b1) begin
				culled_seen++;
			end
			if (pending_culls.size() == 0) begin
				flag_error($sformatf("result word with nothing expected, culled=%b", culled));
			end else begin
				e = pending_culls.pop_front();
				if (culled !== e.cull) begin
					flag_error($sformatf("word %0d: culled expected %b, got %b",
						e.seq, e.cull, culled));
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/fcbs_pkg.sv
sv/frustum_cull_box_sphere.sv
tb/sv/tb_frustum_cull_box_sphere.sv
